// ===== rtl/shabh_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 block hasher.
`default_nettype none

package shabh_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned WCNT_W      = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W     = $clog2(ROUNDS);
  localparam int unsigned IDX_W       = $clog2(HASH_WORDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t hash_t [HASH_WORDS];

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam hash_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t small_sig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/shabh_ifs.sv =====
// Request channels of the SHA-256 block hasher: message words in, digest words out.
`default_nettype none

interface shabh_in_if;
  logic                valid;
  logic                ready;
  shabh_pkg::word_t    message_word;
  logic                start_message;
  logic                final_block;

  modport source (output valid, output message_word, output start_message,
                  output final_block, input ready);
  modport sink   (input valid, input message_word, input start_message,
                  input final_block, output ready);
endinterface

interface shabh_out_if;
  logic                          valid;
  logic                          ready;
  shabh_pkg::word_t              digest_word;
  logic [shabh_pkg::IDX_W-1:0]   digest_index;
  logic                          digest_last;

  modport source (output valid, output digest_word, output digest_index,
                  output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_index,
                  input digest_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sha256_block_hasher_unit.sv =====
// SHA-256 block hasher top level: word collection, round sequencer, digest output.
// Takes a padded message one 32-bit word per request, most significant word first.
// Words 0..14 of a block are taken one per cycle. The sixteenth word starts the
// compression: the rounds on the shared round unit (one round and one schedule word
// per cycle), then an add step into the chaining words; in_ch.ready is low during
// the rounds. start_message reloads the initial hash values on the word that carries
// it; final_block is looked at only on the sixteenth word and, when set, the eight
// digest words follow (index 0 first, digest_last on index 7) before the next word
// is taken. Blocks are not realigned by start_message.
`default_nettype none

module sha256_block_hasher_unit (
  input  logic       clk,
  input  logic       rst_n,
  shabh_in_if.sink   in_ch,
  shabh_out_if.source out_ch
);
  import shabh_pkg::*;

  localparam logic [WCNT_W-1:0]  LAST_WORD  = WCNT_W'(BLOCK_WORDS - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(HASH_WORDS - 1);

  state_t              state_r, state_nxt;
  logic [WCNT_W-1:0]   word_count_r;
  logic [ROUND_W-1:0]  round_r;
  logic [IDX_W-1:0]    emit_idx_r;
  logic                final_r;
  hash_t               chain_r;
  hash_t               chain_base;
  hash_t               vars_r;
  hash_t               vars_round;
  word_t               win_r [BLOCK_WORDS];
  word_t               sched_new;
  logic                in_fire;
  logic                out_fire;
  logic                block_full;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_fire   = out_ch.valid && out_ch.ready;
  assign block_full = in_fire && (word_count_r == LAST_WORD);

  // window holds W[t..t+15] at round t; W[t+16] shifts in at the top
  assign sched_new = small_sig1(win_r[14]) + win_r[9] + small_sig0(win_r[1]) + win_r[0];

  always_comb begin
    for (int i = 0; i < HASH_WORDS; i++) begin
      chain_base[i] = in_ch.start_message ? INIT_HASH[i] : chain_r[i];
    end
  end

  shabh_round u_round (
    .vars_i (vars_r),
    .w_i    (win_r[0]),
    .k_i    (ROUND_K[round_r]),
    .vars_o (vars_round)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_COLLECT: begin
        in_ch.ready = 1'b1;
        if (block_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = final_r ? ST_EMIT : ST_COLLECT;
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_fire && emit_idx_r == LAST_IDX) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  assign out_ch.digest_word  = chain_r[emit_idx_r];
  assign out_ch.digest_index = emit_idx_r;
  assign out_ch.digest_last  = (emit_idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= '0;
      round_r      <= '0;
      emit_idx_r   <= '0;
      final_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        word_count_r <= word_count_r + 1'b1;
      end
      if (block_full) begin
        final_r <= in_ch.final_block;
        round_r <= '0;
      end else if (state_r == ST_ROUND) begin
        round_r <= round_r + 1'b1;
      end
      if (out_fire) begin
        emit_idx_r <= emit_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= INIT_HASH;
    end else if (in_fire && in_ch.start_message) begin
      chain_r <= INIT_HASH;
    end else if (state_r == ST_ADD) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain_r[i] <= chain_r[i] + vars_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (block_full) begin
      vars_r <= chain_base;
    end else if (state_r == ST_ROUND) begin
      vars_r <= vars_round;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r[word_count_r] <= in_ch.message_word;
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BLOCK_WORDS-1] <= sched_new;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("digest output overlaps word intake");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    block_full |=> (state_r == ST_ROUND && round_r == '0))
    else $error("full block did not start compression at round zero");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_COLLECT) |-> (word_count_r == '0))
    else $error("word count nonzero outside collection");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.digest_last) |=> (state_r == ST_COLLECT && emit_idx_r == '0))
    else $error("digest output did not end after last word");
`endif

endmodule

`default_nettype wire

// ===== rtl/shabh_round.sv =====
// One SHA-256 compression round over the working variables a..h.
`default_nettype none

module shabh_round (
  input  shabh_pkg::hash_t vars_i,
  input  shabh_pkg::word_t w_i,
  input  shabh_pkg::word_t k_i,
  output shabh_pkg::hash_t vars_o
);
  import shabh_pkg::*;

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  always_comb begin
    ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t1  = vars_i[7] + big_sig1(vars_i[4]) + ch + k_i + w_i;
    t2  = big_sig0(vars_i[0]) + maj;
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;
  end

endmodule

`default_nettype wire
